// File: rtl/tick_timer_bank_with_ramps_top_assert.svh
// Assertion helpers for the tick timer bank.
`ifndef TICK_TIMER_BANK_WITH_RAMPS_TOP_ASSERT_SVH
`define TICK_TIMER_BANK_WITH_RAMPS_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TBR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TBR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/tbr_pkg.sv
package tbr_pkg;

  localparam int RAMP_CHANNELS = 4;
  localparam int TIMER_UNITS   = 11;

  localparam int UNIT_W  = 4;
  localparam int VAL_W   = 32;
  localparam int WORD_W  = 16;
  localparam int RAMP_AW = (RAMP_CHANNELS > 1) ? $clog2(RAMP_CHANNELS) : 1;
  localparam int TMR_AW  = $clog2(TIMER_UNITS);
  localparam int CFG_IW  = 1;

  localparam logic [UNIT_W:0] RAMP_N = (UNIT_W + 1)'(RAMP_CHANNELS);
  localparam logic [UNIT_W:0] TMR_N  = (UNIT_W + 1)'(TIMER_UNITS);
  localparam logic [UNIT_W-1:0] LAST_UNIT = UNIT_W'(TIMER_UNITS - 1);

  localparam logic [UNIT_W-1:0] RELOAD_UNIT_A = UNIT_W'(8);
  localparam logic [UNIT_W-1:0] RELOAD_UNIT_B = UNIT_W'(9);

  // request codes
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_LOAD  = 2'd2;

  // event codes
  localparam logic [1:0] EV_STEP   = 2'd0;
  localparam logic [1:0] EV_DONE   = 2'd1;
  localparam logic [1:0] EV_EXPIRE = 2'd2;

  // ramp channel status
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_STOP = 2'd2;

  // config register indexes
  localparam logic [CFG_IW-1:0] REG_RELOAD_A = 1'd0;
  localparam logic [CFG_IW-1:0] REG_RELOAD_B = 1'd1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_FLUSH
  } state_t;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [UNIT_W-1:0] unit;
    logic [31:0]       start_value;
    logic signed [31:0] step;
    logic [15:0]       limit;
    logic [15:0]       load_count;
  } in_t;

  typedef struct packed {
    logic [1:0]        event_kind;
    logic [UNIT_W-1:0] unit_index;
    logic [15:0]       dac_word;
    logic              last;
  } out_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [UNIT_W-1:0] unit;
    logic [WORD_W-1:0] dac;
  } ev_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [WORD_W-1:0] limit;
    logic [VAL_W-1:0]  step;
    logic [VAL_W-1:0]  value;
  } ramp_ent_t;

  typedef struct packed {
    logic              ramp_we;
    ramp_ent_t         ramp_wdata;
    logic              tmr_we;
    logic [WORD_W-1:0] tmr_wdata;
    logic              ev_valid;
    ev_t               ev;
  } step_res_t;

  typedef struct packed {
    logic push;
    logic flush;
  } evb_ctl_t;

  typedef struct packed {
    logic room;
    logic flush_ok;
  } evb_st_t;

endpackage

// File: rtl/tbr_ram.sv
module tbr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             rd_en,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/tbr_step.sv
module tbr_step import tbr_pkg::*; (
  input  logic [UNIT_W-1:0] unit,
  input  ramp_ent_t         ramp_ent,
  input  logic [WORD_W-1:0] count,
  input  logic [WORD_W-1:0] reload_a,
  input  logic [WORD_W-1:0] reload_b,
  output step_res_t         res
);

  logic              is_ramp;
  logic [WORD_W-1:0] ip;
  logic              reached;
  logic [VAL_W-1:0]  sum;
  logic [WORD_W-1:0] cnt_dec;

  always_comb begin
    is_ramp = {1'b0, unit} < RAMP_N;
    ip      = ramp_ent.value[VAL_W-1:WORD_W];
    reached = ramp_ent.step[VAL_W-1] ? (ip <= ramp_ent.limit) : (ip >= ramp_ent.limit);
    sum     = ramp_ent.value + ramp_ent.step;
    cnt_dec = count - WORD_W'(1);

    res          = '0;
    res.ev.unit  = unit;
    res.ramp_wdata = ramp_ent;

    if (is_ramp) begin
      if (ramp_ent.status == ST_RUN) begin
        res.ramp_we  = 1'b1;
        res.ev_valid = 1'b1;
        if (reached) begin
          // pin integer part to the limit, keep fraction
          res.ramp_wdata.value  = {ramp_ent.limit, ramp_ent.value[WORD_W-1:0]};
          res.ramp_wdata.status = ST_STOP;
          res.ev.kind = EV_DONE;
          res.ev.dac  = ramp_ent.limit;
        end else begin
          res.ramp_wdata.value = sum;
          res.ev.kind = EV_STEP;
          res.ev.dac  = sum[VAL_W-1:WORD_W];
        end
      end
    end else if (count != '0) begin
      res.tmr_we    = 1'b1;
      res.tmr_wdata = cnt_dec;
      if (cnt_dec == '0) begin
        res.ev_valid = 1'b1;
        res.ev.kind  = EV_EXPIRE;
        if (unit == RELOAD_UNIT_A) begin
          res.tmr_wdata = reload_a;
        end else if (unit == RELOAD_UNIT_B) begin
          res.tmr_wdata = reload_b;
        end
      end
    end
  end

endmodule

// File: rtl/tbr_evbuf.sv
module tbr_evbuf import tbr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  evb_ctl_t ctl,
  input  ev_t      ev,
  output evb_st_t  st,
  output logic     out_valid,
  input  logic     out_stall,
  output out_t     out_data
);

  // one event held back until we know whether it ends the tick
  logic pend_valid;
  ev_t  pend;
  logic out_free;
  logic out_load;

  always_comb begin
    out_free    = !out_valid || !out_stall;
    st.room     = !pend_valid || out_free;
    st.flush_ok = !pend_valid || out_free;
    out_load    = pend_valid && out_free && (ctl.push || ctl.flush);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (ctl.push && st.room) begin
        pend_valid <= 1'b1;
      end else if (ctl.flush && out_load) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.event_kind <= pend.kind;
      out_data.unit_index <= pend.unit;
      out_data.dac_word   <= pend.dac;
      out_data.last       <= ctl.flush;
    end
    if (ctl.push && st.room) begin
      pend <= ev;
    end
  end

endmodule

// File: rtl/tick_timer_bank_with_ramps_top.sv
// Start and load beats: no events.
// Tick beat: sweeps TIMER_UNITS units one per cycle from a registered RAM read
// while the event buffer has room, then a flush state.
// Each event waits for the next one; the last is loaded at the flush edge.
// Output stall holds the sweep only with two waiting.
// Reset (rst, sync, active high) idles the FSM and clears valid bits and periods.
`include "tick_timer_bank_with_ramps_top_assert.svh"

module tick_timer_bank_with_ramps_top import tbr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_t               in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_t              out_data,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [WORD_W-1:0] cfg_data
);

  state_t state, state_next;
  logic [UNIT_W-1:0] ex_unit, ex_unit_next;

  // reload period registers
  logic [WORD_W-1:0] reload_a, reload_b;

  // memory ports
  logic               rd_en;
  logic [UNIT_W-1:0]  rd_unit;
  logic [RAMP_AW-1:0] ramp_raddr, ramp_waddr;
  logic [TMR_AW-1:0]  tmr_raddr, tmr_waddr;
  logic               ramp_we, tmr_we;
  ramp_ent_t          ramp_wdata, ramp_rdata, ramp_ent;
  logic [WORD_W-1:0]  tmr_wdata, tmr_rdata, tmr_cnt;

  // per-entry valid bits: an entry never written reads as zero / idle
  logic ramp_vld [RAMP_CHANNELS];
  logic tmr_vld  [TIMER_UNITS];
  logic ramp_vq, tmr_vq;

  step_res_t res;
  evb_ctl_t  evb_ctl;
  evb_st_t   evb_st;
  logic      in_acc;
  logic      start_ok, load_ok;

  assign in_acc   = in_valid && !in_stall;
  assign start_ok = {1'b0, in_data.unit} < RAMP_N;
  assign load_ok  = ({1'b0, in_data.unit} >= RAMP_N) && ({1'b0, in_data.unit} < TMR_N);

  assign ramp_raddr = ({1'b0, rd_unit} < RAMP_N) ? rd_unit[RAMP_AW-1:0] : '0;
  assign tmr_raddr  = rd_unit[TMR_AW-1:0];
  assign ramp_ent   = ramp_vq ? ramp_rdata : '0;
  assign tmr_cnt    = tmr_vq ? tmr_rdata : '0;

  tbr_ram #(.WIDTH($bits(ramp_ent_t)), .DEPTH(RAMP_CHANNELS)) u_ramp_ram (
    .clk   (clk),
    .we    (ramp_we),
    .waddr (ramp_waddr),
    .wdata (ramp_wdata),
    .rd_en (rd_en),
    .raddr (ramp_raddr),
    .rdata (ramp_rdata)
  );

  tbr_ram #(.WIDTH(WORD_W), .DEPTH(TIMER_UNITS)) u_tmr_ram (
    .clk   (clk),
    .we    (tmr_we),
    .waddr (tmr_waddr),
    .wdata (tmr_wdata),
    .rd_en (rd_en),
    .raddr (tmr_raddr),
    .rdata (tmr_rdata)
  );

  tbr_step u_step (
    .unit     (ex_unit),
    .ramp_ent (ramp_ent),
    .count    (tmr_cnt),
    .reload_a (reload_a),
    .reload_b (reload_b),
    .res      (res)
  );

  tbr_evbuf u_evbuf (
    .clk       (clk),
    .rst       (rst),
    .ctl       (evb_ctl),
    .ev        (res.ev),
    .st        (evb_st),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Sequencer: read of unit u+1 is issued as unit u retires, so each sweep
  // cycle sees fresh data. Different units never collide, so no forwarding.
  always_comb begin
    state_next   = state;
    ex_unit_next = ex_unit;
    in_stall     = 1'b1;
    rd_en        = 1'b0;
    rd_unit      = ex_unit + UNIT_W'(1);
    evb_ctl      = '0;
    ramp_we      = 1'b0;
    ramp_waddr   = ex_unit[RAMP_AW-1:0];
    ramp_wdata   = res.ramp_wdata;
    tmr_we       = 1'b0;
    tmr_waddr    = ex_unit[TMR_AW-1:0];
    tmr_wdata    = res.tmr_wdata;

    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          case (in_data.req_type)
            REQ_TICK: begin
              rd_en        = 1'b1;
              rd_unit      = '0;
              ex_unit_next = '0;
              state_next   = S_SWEEP;
            end
            REQ_START: begin
              ramp_we    = start_ok;
              ramp_waddr = in_data.unit[RAMP_AW-1:0];
              ramp_wdata.value  = in_data.start_value;
              ramp_wdata.step   = in_data.step;
              ramp_wdata.limit  = in_data.limit;
              ramp_wdata.status = ST_RUN;
            end
            REQ_LOAD: begin
              tmr_we    = load_ok;
              tmr_waddr = in_data.unit[TMR_AW-1:0];
              tmr_wdata = in_data.load_count;
            end
            default: begin
            end
          endcase
        end
      end
      S_SWEEP: begin
        // hold the unit while the event buffer is full
        if (!res.ev_valid || evb_st.room) begin
          evb_ctl.push = res.ev_valid;
          ramp_we      = res.ramp_we;
          tmr_we       = res.tmr_we;
          if (ex_unit == LAST_UNIT) begin
            state_next = S_FLUSH;
          end else begin
            rd_en        = 1'b1;
            ex_unit_next = ex_unit + UNIT_W'(1);
          end
        end
      end
      S_FLUSH: begin
        evb_ctl.flush = 1'b1;
        if (evb_st.flush_ok) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      ex_unit  <= '0;
      reload_a <= '0;
      reload_b <= '0;
      for (int i = 0; i < RAMP_CHANNELS; i++) begin
        ramp_vld[i] <= 1'b0;
      end
      for (int i = 0; i < TIMER_UNITS; i++) begin
        tmr_vld[i] <= 1'b0;
      end
    end else begin
      state   <= state_next;
      ex_unit <= ex_unit_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_RELOAD_A: reload_a <= cfg_data;
          REG_RELOAD_B: reload_b <= cfg_data;
          default: begin
          end
        endcase
      end
      if (ramp_we) begin
        ramp_vld[ramp_waddr] <= 1'b1;
      end
      if (tmr_we) begin
        tmr_vld[tmr_waddr] <= 1'b1;
      end
    end
  end

  // valid bits travel with the registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      ramp_vq <= ramp_vld[ramp_raddr];
      tmr_vq  <= tmr_vld[tmr_raddr];
    end
  end

  `TBR_ASSERT_NOW(a_push_room, evb_ctl.push, evb_st.room, "event pushed into full buffer")
  `TBR_ASSERT_NOW(a_unit_range, state == S_SWEEP, {1'b0, ex_unit} < TMR_N, "sweep unit out of range")
  `TBR_ASSERT_NXT(a_tick_sweep, in_acc && in_data.req_type == REQ_TICK, state == S_SWEEP && ex_unit == '0, "tick did not start sweep")
  `TBR_ASSERT_NOW(a_idle_nowr, state == S_IDLE && !in_acc, !ramp_we && !tmr_we, "memory write while idle")

endmodule
